FILE: hdl/binned_count_histogram_top_assert.svh
// assertion macros for the histogram top level
`ifndef BINNED_COUNT_HISTOGRAM_TOP_ASSERT_SVH
`define BINNED_COUNT_HISTOGRAM_TOP_ASSERT_SVH
// condition implies consequence on the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
// condition implies consequence in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`endif

FILE: hdl/bch_pkg.sv
// package for the histogram: constants, item types and the front-to-back job struct
`timescale 1ns / 1ps
package bch_pkg;
	localparam int MAX_BINS_DEF = 1024;
	localparam int COUNT_BITS_DEF = 32;
	localparam int IDX_BITS = 10;
	localparam logic [1:0] REG_LOW = 2'd0;
	localparam logic [1:0] REG_HIGH = 2'd1;
	localparam logic [1:0] REG_WIDTH = 2'd2;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic kind;
		logic [31:0] sample_value;
		logic [IDX_BITS-1:0] bin_index;
	} in_item_t;

	typedef struct packed {
		logic [32:0] bin_start;
		logic [31:0] bin_count;
		logic in_use;
	} out_item_t;

	// work handed from front to back
	typedef struct packed {
		logic kind;
		logic [16:0] idx;
		logic [32:0] start;
		logic in_use;
		logic in_store;
	} job_t;
endpackage

FILE: hdl/bch_ram.sv
// generic single-port-write, single-read RAM with registered read
`timescale 1ns / 1ps
module bch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/bch_div.sv
// restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module bch_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [33:0] num,
	input logic [31:0] den,
	output logic busy,
	output logic done,
	output logic [33:0] quo
);
	logic [31:0] rem_q, den_q;
	logic [33:0] quo_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;
	assign trial = {rem_q, quo_q[33]} - {1'b0, den_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start && !busy) begin
				busy <= 1'b1;
				cnt_q <= 6'd34;
			end else if (busy) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[33]};
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end
	assign quo = quo_q;
endmodule

FILE: hdl/bch_front.sv
// front: takes items, works out the bin count, divides samples into bin indices, works out read bin start
`timescale 1ns / 1ps
module bch_front import bch_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [31:0] low_q,
	input logic [31:0] high_q,
	input logic [31:0] width_q,
	input logic push,
	output logic full,
	input in_item_t in_item,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_NBIN = 5'b00010,
		ST_DIV = 5'b00100,
		ST_MUL = 5'b01000,
		ST_OUT = 5'b10000
	} st_t;
	st_t st_q;
	in_item_t item_q;
	logic [33:0] w, base, ceilv, top;
	logic [33:0] nbins_q;
	logic [16:0] idx_q;
	logic [32:0] start_q;
	logic dstart, dbusy, ddone;
	logic [33:0] dnum, dquo;
	logic [31:0] dden;
	logic nb_phase_q;
	logic [65:0] prod;

	assign w = (width_q == '0) ? 34'd1 : {2'b0, width_q};
	assign base = (low_q > 32'd1 && w < {2'b0, low_q}) ? {2'b0, low_q} - w : 34'd1;
	assign ceilv = {2'b0, high_q} + w;
	assign top = ceilv + w;
	assign dden = w[31:0];
	assign dnum = nb_phase_q ? (top - base) : ({2'b0, item_q.sample_value} - base);
	assign dstart = (st_q == ST_NBIN) || (st_q == ST_DIV && !nb_phase_q && !dbusy && !ddone);
	assign prod = {32'b0, base} + {24'b0, item_q.bin_index} * {32'b0, w};

	bch_div u_div (.clk, .arst_n, .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quo(dquo));

	assign full = (st_q != ST_IDLE);
	assign job_valid = (st_q == ST_OUT);

	always_comb begin
		job.kind = item_q.kind;
		job.idx = idx_q;
		job.start = start_q;
		job.in_use = ({24'b0, item_q.bin_index} < nbins_q);
		job.in_store = ({7'b0, item_q.bin_index} < 17'(MAX_BINS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			nb_phase_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (push) begin
					st_q <= ST_NBIN;
					nb_phase_q <= 1'b1;
				end
				ST_NBIN: st_q <= ST_DIV;
				ST_DIV: if (ddone) begin
					if (nb_phase_q) begin
						nb_phase_q <= 1'b0;
						if (item_q.kind == KIND_READ) st_q <= ST_MUL;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_MUL: st_q <= ST_OUT;
				ST_OUT: if (job_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && push) item_q <= in_item;
		if (st_q == ST_DIV && ddone && nb_phase_q) begin
			if (top < base || dquo == '0) nbins_q <= 34'd1;
			else if (dquo > 34'(MAX_BINS)) nbins_q <= 34'(MAX_BINS);
			else nbins_q <= dquo;
		end
		if (st_q == ST_DIV && ddone && !nb_phase_q) begin
			if ({2'b0, item_q.sample_value} < base) idx_q <= '0;
			else if ({2'b0, item_q.sample_value} > ceilv
				|| dquo > nbins_q - 34'd1) idx_q <= 17'(nbins_q - 34'd1);
			else idx_q <= 17'(dquo);
		end
		if (st_q == ST_MUL) begin
			start_q <= (prod > 66'h1_FFFF_FFFF) ? '1 : prod[32:0];
			idx_q <= {7'b0, item_q.bin_index};
		end
	end
endmodule

FILE: hdl/bch_back.sv
// back: clearing pass, job queue, counter read-modify-write, reads and result output register
`timescale 1ns / 1ps
module bch_back import bch_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic empty,
	input logic pop,
	output out_item_t out_item,
	output logic clearing
);
	localparam int AW = $clog2(MAX_BINS);
	typedef enum logic [3:0] {
		B_CLR = 4'b0001,
		B_IDLE = 4'b0010,
		B_RD = 4'b0100,
		B_WR = 4'b1000
	} bst_t;
	bst_t st_q;
	job_t q_q [2];
	logic [1:0] cnt_q;
	logic wptr_q, rptr_q;
	job_t cur_q;
	logic [AW-1:0] clr_q;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [COUNT_BITS-1:0] wdata, rdata;
	logic out_full_q;
	logic take;
	logic push_q;

	assign job_ready = (cnt_q != 2'd2);
	assign push_q = job_valid && job_ready;
	assign take = (st_q == B_IDLE) && (cnt_q != 2'd0)
		&& (q_q[rptr_q].kind == KIND_SAMPLE || !out_full_q);
	assign raddr = (st_q == B_IDLE) ? AW'(q_q[rptr_q].idx) : AW'(cur_q.idx);
	assign we = (st_q == B_CLR) || (st_q == B_WR && cur_q.kind == KIND_SAMPLE);
	assign waddr = (st_q == B_CLR) ? clr_q : AW'(cur_q.idx);
	assign wdata = (st_q == B_CLR) ? '0 : ((&rdata) ? rdata : rdata + 1'b1);
	assign empty = !out_full_q;
	assign clearing = (st_q == B_CLR);

	bch_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_ram (.clk, .we, .waddr, .wdata,
		.raddr, .rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push_q) - 2'(take);
			if (push_q) wptr_q <= !wptr_q;
			if (take) rptr_q <= !rptr_q;
			if (pop && out_full_q) out_full_q <= 1'b0;
			case (st_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_BINS - 1)) st_q <= B_IDLE;
				end
				B_IDLE: if (take) st_q <= B_RD;
				B_RD: st_q <= B_WR;
				B_WR: begin
					st_q <= B_IDLE;
					if (cur_q.kind == KIND_READ) out_full_q <= 1'b1;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_q) q_q[wptr_q] <= job;
		if (take) cur_q <= q_q[rptr_q];
		if (st_q == B_WR && cur_q.kind == KIND_READ) begin
			out_item.bin_start <= cur_q.start;
			out_item.bin_count <= cur_q.in_store
				? ((COUNT_BITS > 32 && (rdata >> 32) != '0) ? 32'hFFFF_FFFF : 32'(rdata))
				: '0;
			out_item.in_use <= cur_q.in_store && cur_q.in_use;
		end
	end
endmodule

FILE: hdl/binned_count_histogram_top.sv
// top level of the fixed-width bin histogram
// the front handles one item at a time: one division for a read, two for a sample,
// and it stays full until its job is handed to the back part
// the counter store is read-modify-written in the back part behind a two-entry queue
// reset: asynchronous, registers to reset values, then a clearing pass through every
// word of the counter memory during which no item is accepted
`timescale 1ns / 1ps
`include "binned_count_histogram_top_assert.svh"
module binned_count_histogram_top import bch_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t in_item,
	output logic empty,
	input logic pop,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic [31:0] low_q, high_q, width_q;
	logic job_valid, job_ready, clearing, front_full;
	job_t job;

	assign cfg_ready = 1'b1;
	assign full = front_full || clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 32'd1;
			high_q <= 32'd10000;
			width_q <= 32'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW: low_q <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				REG_WIDTH: width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bch_front #(.MAX_BINS(MAX_BINS)) u_front (.clk, .arst_n, .low_q, .high_q, .width_q,
		.push(push && !clearing), .full(front_full), .in_item, .job_valid, .job_ready, .job);

	bch_back #(.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS)) u_back (.clk, .arst_n,
		.job_valid, .job_ready, .job, .empty, .pop, .out_item, .clearing);

	`ASSERT_SAME(a_no_take_clr, clk, arst_n, clearing, full)
	`ASSERT_NEXT(a_hold_out, clk, arst_n, !empty && !pop, !empty && $stable(out_item))
	`ASSERT_NEXT(a_busy_after, clk, arst_n, push && !full, full)
endmodule

FILE: dv/tb_binned_count_histogram_top.sv
// self-checking testbench for the fixed-width bin histogram top level
`timescale 1ns / 1ps
module tb_binned_count_histogram_top;
	import bch_pkg::*;

	localparam int STORE_DEPTH = MAX_BINS_DEF;
	localparam int PHASE_COUNT = 9;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [63:0] MASK33 = 64'h1_FFFF_FFFF;

	typedef struct {
		logic kind;
		logic [31:0] sample_value;
		logic [9:0] bin_index;
		bit typed_in;
		out_item_t typed_result;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t in_item;
	logic empty;
	logic pop;
	out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] hist_low, hist_high, hist_width;
	logic [31:0] hist_counts [STORE_DEPTH];
	out_item_t pending_reads[$];
	int mismatches;
	longint cycles;
	int send_idle_pct, recv_idle_pct;

	binned_count_histogram_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] eff_width();
		return (hist_width == 0) ? 64'd1 : 64'(hist_width);
	endfunction

	function automatic logic [63:0] first_edge();
		logic [63:0] w;
		w = eff_width();
		if (hist_low > 1 && w < hist_low)
			return 64'(hist_low) - w;
		return 64'd1;
	endfunction

	function automatic logic [63:0] bins_used();
		logic [63:0] w, b, top, n;
		w = eff_width();
		b = first_edge();
		top = 64'(hist_high) + w + w;
		if (top < b)
			return 64'd1;
		n = (top - b) / w;
		if (n < 1)
			n = 1;
		if (n > STORE_DEPTH)
			n = STORE_DEPTH;
		return n;
	endfunction

	// update the counters or work out the read-back for one accepted item
	function automatic void histogram_apply(input in_item_t it, input bit typed_in,
			input out_item_t typed_result);
		logic [63:0] w, b, n, v, idx, start;
		out_item_t r;
		w = eff_width();
		b = first_edge();
		n = bins_used();
		if (it.kind == KIND_SAMPLE) begin
			v = 64'(it.sample_value);
			if (v < b)
				idx = 0;
			else if (v > 64'(hist_high) + w)
				idx = n - 1;
			else
				idx = (v - b) / w;
			if (idx > n - 1)
				idx = n - 1;
			if (hist_counts[idx] != 32'hFFFF_FFFF)
				hist_counts[idx] = hist_counts[idx] + 1;
		end else begin
			start = b + 64'(it.bin_index) * w;
			if (start > MASK33)
				start = MASK33;
			r.bin_start = start[32:0];
			r.bin_count = hist_counts[it.bin_index];
			r.in_use = (64'(it.bin_index) < n);
			pending_reads.push_back(typed_in ? typed_result : r);
		end
	endfunction

	task automatic send_item(input in_item_t it, input bit typed_in, input out_item_t typed_result);
		bit taken;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct) begin
				push = 1'b0;
			end else begin
				push = 1'b1;
				in_item = it;
			end
			@(posedge clk);
			if (push && !full)
				taken = 1;
		end
		histogram_apply(it, typed_in, typed_result);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LOW: hist_low = data;
			REG_HIGH: hist_high = data;
			REG_WIDTH: hist_width = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (pending_reads.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		logic [63:0] w, b, n, v;
		w = eff_width();
		b = first_edge();
		n = bins_used();
		it.sample_value = $urandom;
		it.bin_index = 10'($urandom);
		if ($urandom_range(99) < 60) begin
			it.kind = KIND_SAMPLE;
			case ($urandom_range(9))
				0: it.sample_value = 32'd0;
				1: it.sample_value = 32'hFFFF_FFFF;
				2: ;
				default: begin
					v = b + (64'($urandom) % (n * w + 1));
					it.sample_value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
				end
			endcase
		end else begin
			it.kind = KIND_READ;
			if ($urandom_range(99) < 70)
				it.bin_index = 10'($urandom_range((n + 2 > 1023) ? 1023 : int'(n + 2)));
		end
		return it;
	endfunction

	// receiver: pops with random stalls and checks against the oldest prediction
	always begin
		out_item_t want;
		@(negedge clk);
		pop = ($urandom_range(99) >= recv_idle_pct);
		@(posedge clk);
		if (arst_n && pop && !empty) begin
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: start %h count %h in_use %b",
						out_item.bin_start, out_item.bin_count, out_item.in_use);
			end else begin
				want = pending_reads.pop_front();
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp start %h count %h in_use %b, got %h %h %b",
							want.bin_start, want.bin_count, want.in_use,
							out_item.bin_start, out_item.bin_count, out_item.in_use);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		directed_row_t rows [$];
		directed_row_t row;
		in_item_t it;
		out_item_t none;
		logic [31:0] phase_low [PHASE_COUNT];
		logic [31:0] phase_high [PHASE_COUNT];
		logic [31:0] phase_width [PHASE_COUNT];
		int sent;

		push = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_LOW;
		cfg_data = '0;
		send_idle_pct = 19;
		recv_idle_pct = 59;
		none = '0;
		hist_low = 32'd1;
		hist_high = 32'd10000;
		hist_width = 32'd1;
		foreach (hist_counts[i])
			hist_counts[i] = '0;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: cleared store, extreme indices and sample values
		rows.push_back('{KIND_READ, 32'd0, 10'd0, 1, '{33'd1, 32'd0, 1'b1}});
		rows.push_back('{KIND_READ, 32'd0, 10'd1023, 1, '{33'd1024, 32'd0, 1'b1}});
		rows.push_back('{KIND_SAMPLE, 32'd0, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'hFFFF_FFFF, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'd1, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'd5, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'd10001, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'd10002, 10'd0, 0, none});
		rows.push_back('{KIND_SAMPLE, 32'd1023, 10'd0, 0, none});
		rows.push_back('{KIND_READ, 32'd0, 10'd0, 0, none});
		rows.push_back('{KIND_READ, 32'd0, 10'd4, 0, none});
		rows.push_back('{KIND_READ, 32'd0, 10'd1022, 0, none});
		rows.push_back('{KIND_READ, 32'd0, 10'd1023, 0, none});
		foreach (rows[i]) begin
			row = rows[i];
			it.kind = row.kind;
			it.sample_value = row.sample_value;
			it.bin_index = row.bin_index;
			send_item(it, row.typed_in, row.typed_result);
		end
		drain();

		// register settings: zero width and low, all ones, ordinary, empty range,
		// wide bins, too many bins, then random ones
		phase_low = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd1000, 32'd5, 32'd1, 0, 0, 0};
		phase_high = '{32'd0, 32'hFFFF_FFFF, 32'd200, 32'd0, 32'd3, 32'd10000, 0, 0, 0};
		phase_width = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'd1, 32'd1000, 32'd1, 0, 0, 0};
		for (int p = 6; p < PHASE_COUNT; p++) begin
			phase_low[p] = $urandom_range(1, 500);
			phase_high[p] = phase_low[p] + $urandom_range(0, 3000);
			phase_width[p] = $urandom_range(1, 20);
		end

		sent = 0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_reg(REG_LOW, phase_low[p]);
			write_reg(REG_HIGH, phase_high[p]);
			write_reg(REG_WIDTH, phase_width[p]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				case (sent / 450)
					0: begin
						send_idle_pct = 19;
						recv_idle_pct = 59;
					end
					1: begin
						send_idle_pct = 59;
						recv_idle_pct = 19;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				send_item(random_item(), 0, none);
				sent++;
			end
			drain();
		end

		if (mismatches == 0 && pending_reads.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
